// ===== sv/hrp_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP request header parser package
// Shared types, codes, character constants, character-class and digit functions.
// ----------------------------------------------------------------------------
package hrp_pkg;

	// Parser states of the request line and header block grammar.
	typedef enum logic [4:0] {
		ST_METHOD_START       = 5'd0,
		ST_METHOD             = 5'd1,
		ST_URI                = 5'd2,
		ST_VER_H              = 5'd3,
		ST_VER_T1             = 5'd4,
		ST_VER_T2             = 5'd5,
		ST_VER_P              = 5'd6,
		ST_VER_SLASH          = 5'd7,
		ST_MAJOR_START        = 5'd8,
		ST_MAJOR              = 5'd9,
		ST_MINOR_START        = 5'd10,
		ST_MINOR              = 5'd11,
		ST_NL1                = 5'd12,
		ST_LINE_START         = 5'd13,
		ST_LWS                = 5'd14,
		ST_HNAME              = 5'd15,
		ST_SPACE_BEFORE_VALUE = 5'd16,
		ST_HVALUE             = 5'd17,
		ST_NL2                = 5'd18,
		ST_NL3                = 5'd19
	} parse_state_t;

	// Status codes.
	localparam logic [1:0] RES_MORE = 2'd0;
	localparam logic [1:0] RES_DONE = 2'd1;
	localparam logic [1:0] RES_BAD  = 2'd2;

	// Field tags.
	localparam logic [2:0] TAG_NONE     = 3'd0;
	localparam logic [2:0] TAG_METHOD   = 3'd1;
	localparam logic [2:0] TAG_URI      = 3'd2;
	localparam logic [2:0] TAG_NEW_NAME = 3'd3;
	localparam logic [2:0] TAG_NAME     = 3'd4;
	localparam logic [2:0] TAG_VALUE    = 3'd5;

	// Operation codes.
	localparam logic OP_CONSUME = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// Characters of the grammar.
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_LAST_CTL = 8'h1F;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] VER_MAX  = 8'hFF;

	// Parser context kept from one byte to the next.
	typedef struct packed {
		parse_state_t state;
		logic [7:0]   major;
		logic [7:0]   minor;
		logic         header_seen;
	} hrp_ctx_t;

	// Result of one item.
	typedef struct packed {
		logic [1:0] status;
		logic [2:0] tag;
		logic [7:0] data;
		logic [7:0] major;
		logic [7:0] minor;
	} hrp_res_t;

	function automatic logic is_ctl(input logic [7:0] b);
		return (b <= CH_LAST_CTL) || (b == CH_DEL);
	endfunction

	function automatic logic is_separator(input logic [7:0] b);
		logic sep;
		case (b)
			8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40,
			8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
			8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D,
			8'h7B, 8'h7D, 8'h20, 8'h09: sep = 1'b1;
			default: sep = 1'b0;
		endcase
		return sep;
	endfunction

	function automatic logic is_token(input logic [7:0] b);
		return !b[7] && !is_ctl(b) && !is_separator(b);
	endfunction

	function automatic logic is_decimal(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	// Decimal accumulate with saturation at 255.
	function automatic logic [7:0] add_digit(input logic [7:0] v, input logic [7:0] b);
		logic [11:0] n;
		n = 12'(v) * 12'd10 + 12'(b - CH_ZERO);
		return (n > 12'(VER_MAX)) ? VER_MAX : n[7:0];
	endfunction

endpackage

// ===== sv/http_request_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// HTTP request header parser unit
// Byte-at-a-time recognizer for an HTTP request line and header block.
// An item accepted into the input register has its result loaded into the
// result register when the result side advances. Throughput: one item per cycle
// while the result channel does not stall; the parser state loop has one register.
// Reset: asynchronous, active low; the parser returns to the method start
// state with zero version numbers and both pipeline stages empty.
// ----------------------------------------------------------------------------
module http_request_header_parser_unit (
	input  logic       clk,
	input  logic       arst_n,
	// Request byte channel.
	input  logic       req_valid,
	output logic       req_stall,
	input  logic       operation,
	input  logic [7:0] byte_in,
	// Result channel.
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] status,
	output logic [2:0] field_tag,
	output logic [7:0] byte_out,
	output logic [7:0] version_major,
	output logic [7:0] version_minor
);

	// The input register holds one item. The parser context register and the
	// result register are both loaded in the cycle in which that item is
	// evaluated, so a new byte can follow in every cycle while the result side
	// is not stalled. When the result register is full and stalled, an empty
	// input register can still take one item, which keeps the receive side moving.

	logic              valid_s1;
	logic              op_s1;
	logic [7:0]        byte_s1;
	logic              res_valid_q;
	hrp_pkg::hrp_res_t res_q;
	hrp_pkg::hrp_ctx_t ctx_q;
	hrp_pkg::hrp_ctx_t ctx_next;
	hrp_pkg::hrp_res_t res_next;
	logic              advance;

	// The evaluated item moves on whenever the result register is free.
	assign advance   = !res_valid_q || !res_stall;
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	// Payload of the input register carries no reset.
	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			op_s1   <= operation;
			byte_s1 <= byte_in;
		end
	end

	hrp_step u_step (
		.ctx       (ctx_q),
		.operation (op_s1),
		.byte_in   (byte_s1),
		.ctx_next  (ctx_next),
		.res       (res_next)
	);

	// Parser context is control state and resets to the start of a request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.state       <= hrp_pkg::ST_METHOD_START;
			ctx_q.major       <= '0;
			ctx_q.minor       <= '0;
			ctx_q.header_seen <= 1'b0;
			res_valid_q       <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
			if (valid_s1) begin
				ctx_q <= ctx_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res_next;
		end
	end

	assign res_valid     = res_valid_q;
	assign status        = res_q.status;
	assign field_tag     = res_q.tag;
	assign byte_out      = res_q.data;
	assign version_major = res_q.major;
	assign version_minor = res_q.minor;

endmodule

// ===== sv/hrp_step.sv =====
// ----------------------------------------------------------------------------
// HTTP parser step logic
// Next context and result for one consumed or restart item.
// ----------------------------------------------------------------------------
module hrp_step (
	input  hrp_pkg::hrp_ctx_t ctx,
	input  logic              operation,
	input  logic [7:0]        byte_in,
	output hrp_pkg::hrp_ctx_t ctx_next,
	output hrp_pkg::hrp_res_t res
);

	logic [1:0]        st;
	logic [2:0]        tag;
	hrp_pkg::hrp_ctx_t nx;
	logic              lws;

	assign lws = (byte_in == hrp_pkg::CH_SP) || (byte_in == hrp_pkg::CH_TAB);

	always_comb begin
		nx  = ctx;
		st  = hrp_pkg::RES_MORE;
		tag = hrp_pkg::TAG_NONE;
		case (ctx.state)
			hrp_pkg::ST_METHOD_START: begin
				if (hrp_pkg::is_token(byte_in)) begin
					nx.state = hrp_pkg::ST_METHOD;
					tag = hrp_pkg::TAG_METHOD;
				end else st = hrp_pkg::RES_BAD;
			end
			hrp_pkg::ST_METHOD: begin
				if (byte_in == hrp_pkg::CH_SP) nx.state = hrp_pkg::ST_URI;
				else if (hrp_pkg::is_token(byte_in)) tag = hrp_pkg::TAG_METHOD;
				else st = hrp_pkg::RES_BAD;
			end
			hrp_pkg::ST_URI: begin
				if (byte_in == hrp_pkg::CH_SP) nx.state = hrp_pkg::ST_VER_H;
				else if (hrp_pkg::is_ctl(byte_in)) st = hrp_pkg::RES_BAD;
				else tag = hrp_pkg::TAG_URI;
			end
			hrp_pkg::ST_VER_H: begin
				if (byte_in == hrp_pkg::CH_H) nx.state = hrp_pkg::ST_VER_T1;
				else st = hrp_pkg::RES_BAD;
			end
			hrp_pkg::ST_VER_T1: begin
				if (byte_in == hrp_pkg::CH_T) nx.state = hrp_pkg::ST_VER_T2;
				else st = hrp_pkg::RES_BAD;
			end
			hrp_pkg::ST_VER_T2: begin
				if (byte_in == hrp_pkg::CH_T) nx.state = hrp_pkg::ST_VER_P;
				else st = hrp_pkg::RES_BAD;
			end
			hrp_pkg::ST_VER_P: begin
				if (byte_in == hrp_pkg::CH_P) nx.state = hrp_pkg::ST_VER_SLASH;
				else st = hrp_pkg::RES_BAD;
			end
			hrp_pkg::ST_VER_SLASH: begin
				if (byte_in == hrp_pkg::CH_SLASH) begin
					nx.major = '0;
					nx.minor = '0;
					nx.state = hrp_pkg::ST_MAJOR_START;
				end else st = hrp_pkg::RES_BAD;
			end
			hrp_pkg::ST_MAJOR_START: begin
				if (hrp_pkg::is_decimal(byte_in)) begin
					nx.major = hrp_pkg::add_digit(ctx.major, byte_in);
					nx.state = hrp_pkg::ST_MAJOR;
				end else st = hrp_pkg::RES_BAD;
			end
			hrp_pkg::ST_MAJOR: begin
				if (byte_in == hrp_pkg::CH_DOT) nx.state = hrp_pkg::ST_MINOR_START;
				else if (hrp_pkg::is_decimal(byte_in))
					nx.major = hrp_pkg::add_digit(ctx.major, byte_in);
				else st = hrp_pkg::RES_BAD;
			end
			hrp_pkg::ST_MINOR_START: begin
				if (hrp_pkg::is_decimal(byte_in)) begin
					nx.minor = hrp_pkg::add_digit(ctx.minor, byte_in);
					nx.state = hrp_pkg::ST_MINOR;
				end else st = hrp_pkg::RES_BAD;
			end
			hrp_pkg::ST_MINOR: begin
				if (byte_in == hrp_pkg::CH_CR) nx.state = hrp_pkg::ST_NL1;
				else if (hrp_pkg::is_decimal(byte_in))
					nx.minor = hrp_pkg::add_digit(ctx.minor, byte_in);
				else st = hrp_pkg::RES_BAD;
			end
			hrp_pkg::ST_NL1: begin
				if (byte_in == hrp_pkg::CH_LF) nx.state = hrp_pkg::ST_LINE_START;
				else st = hrp_pkg::RES_BAD;
			end
			hrp_pkg::ST_LINE_START: begin
				if (byte_in == hrp_pkg::CH_CR) nx.state = hrp_pkg::ST_NL3;
				else if (ctx.header_seen && lws) nx.state = hrp_pkg::ST_LWS;
				else if (hrp_pkg::is_token(byte_in)) begin
					nx.header_seen = 1'b1;
					tag = hrp_pkg::TAG_NEW_NAME;
					nx.state = hrp_pkg::ST_HNAME;
				end else st = hrp_pkg::RES_BAD;
			end
			hrp_pkg::ST_LWS: begin
				if (byte_in == hrp_pkg::CH_CR) nx.state = hrp_pkg::ST_NL2;
				else if (lws) nx.state = hrp_pkg::ST_LWS;
				else if (hrp_pkg::is_ctl(byte_in)) st = hrp_pkg::RES_BAD;
				else begin
					nx.state = hrp_pkg::ST_HVALUE;
					tag = hrp_pkg::TAG_VALUE;
				end
			end
			hrp_pkg::ST_HNAME: begin
				if (byte_in == hrp_pkg::CH_COLON) nx.state = hrp_pkg::ST_SPACE_BEFORE_VALUE;
				else if (hrp_pkg::is_token(byte_in)) tag = hrp_pkg::TAG_NAME;
				else st = hrp_pkg::RES_BAD;
			end
			hrp_pkg::ST_SPACE_BEFORE_VALUE: begin
				if (byte_in == hrp_pkg::CH_SP) nx.state = hrp_pkg::ST_HVALUE;
				else st = hrp_pkg::RES_BAD;
			end
			hrp_pkg::ST_HVALUE: begin
				if (byte_in == hrp_pkg::CH_CR) nx.state = hrp_pkg::ST_NL2;
				else if (hrp_pkg::is_ctl(byte_in)) st = hrp_pkg::RES_BAD;
				else tag = hrp_pkg::TAG_VALUE;
			end
			hrp_pkg::ST_NL2: begin
				if (byte_in == hrp_pkg::CH_LF) nx.state = hrp_pkg::ST_LINE_START;
				else st = hrp_pkg::RES_BAD;
			end
			hrp_pkg::ST_NL3: begin
				st = (byte_in == hrp_pkg::CH_LF) ? hrp_pkg::RES_DONE : hrp_pkg::RES_BAD;
			end
			default: begin
				st = hrp_pkg::RES_BAD;
			end
		endcase

		// A malformed byte leaves every piece of context untouched.
		if (st == hrp_pkg::RES_BAD) nx = ctx;

		if (operation == hrp_pkg::OP_RESTART) begin
			ctx_next.state       = hrp_pkg::ST_METHOD_START;
			ctx_next.major       = '0;
			ctx_next.minor       = '0;
			ctx_next.header_seen = 1'b0;
			res.status           = hrp_pkg::RES_MORE;
			res.tag              = hrp_pkg::TAG_NONE;
			res.data             = '0;
			res.major            = '0;
			res.minor            = '0;
		end else begin
			ctx_next   = nx;
			res.status = st;
			res.tag    = tag;
			res.data   = byte_in;
			res.major  = nx.major;
			res.minor  = nx.minor;
		end
	end

endmodule

// ===== bench/http_request_header_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request header parser unit testbench
// Feeds request bytes and restarts through the item channel and checks every
// result, field by field and in order, against a cycle-free parser model
// kept inside the bench. It starts with a short directed request that covers
// the byte extremes, version saturation and the repeated end of a request.
// Random whole requests follow, some corrupted, mixed with raw noise. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module http_request_header_parser_unit_tb;

	import hrp_pkg::*;

	// Run length and the safety limit on clock cycles.
	localparam int RANDOM_ITEMS = 950;
	localparam int CYCLE_LIMIT  = 200000;
	// Near the end of the stimulus both sides stop idling.
	localparam int CALM_TAIL    = 120;

	// One request item as the driver presents it.
	typedef struct {
		logic       op;
		logic [7:0] data;
	} req_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	logic       operation = OP_CONSUME;
	logic [7:0] byte_in = 8'd0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [1:0] status;
	logic [2:0] field_tag;
	logic [7:0] byte_out;
	logic [7:0] version_major;
	logic [7:0] version_minor;

	// Items still to be sent, and results still owed by the block.
	req_item_t  pending_bytes[$];
	hrp_res_t   results_due[$];
	hrp_res_t   want;
	req_item_t  next_item;

	int         total_items = 0;
	int         accepted_items = 0;
	int         result_index = 0;
	int         fail_count = 0;
	int         cycle_count = 0;
	int         send_gap = 0;
	int         stall_left = 0;
	// calm switches idling off for the tail of the run; quiet gives stretches
	// without idling in the middle of it. Both change only by nonblocking
	// assignment, so driver and monitor see the same value at an edge.
	logic       calm = 1'b0;
	logic       quiet = 1'b0;

	// Parser context of the bench model.
	parse_state_t model_state = ST_METHOD_START;
	logic [7:0]   model_major = 8'd0;
	logic [7:0]   model_minor = 8'd0;
	logic         model_header_seen = 1'b0;

	http_request_header_parser_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.operation     (operation),
		.byte_in       (byte_in),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.status        (status),
		.field_tag     (field_tag),
		.byte_out      (byte_out),
		.version_major (version_major),
		.version_minor (version_minor)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Character classes of the request grammar.
	// ------------------------------------------------------------------
	function automatic logic control_char(input logic [7:0] b);
		return (b < 8'd32) || (b == CH_DEL);
	endfunction

	function automatic logic separator_char(input logic [7:0] b);
		string seps;
		logic  hit;
		seps = "()<>@,;:\\\"/[]?={} \t";
		hit = 1'b0;
		for (int i = 0; i < seps.len(); i++) begin
			if (seps[i] == b)
				hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic logic token_char(input logic [7:0] b);
		return (b < 8'd128) && !control_char(b) && !separator_char(b);
	endfunction

	function automatic logic decimal_char(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	// Shifts one decimal digit into a version number; the number sticks
	// at 255 once it would go past it.
	function automatic logic [7:0] push_decimal(input logic [7:0] v, input logic [7:0] b);
		int n;
		n = int'(v) * 10 + int'(b) - int'(CH_ZERO);
		return (n > 255) ? VER_MAX : 8'(n);
	endfunction

	// ------------------------------------------------------------------
	// Parser model: advances the bench context by one item and returns the
	// result the block must give for it. A malformed byte changes nothing.
	// ------------------------------------------------------------------
	function automatic hrp_res_t parse_item(input logic op, input logic [7:0] b);
		hrp_res_t     r;
		parse_state_t nxt;
		r.status = RES_MORE;
		r.tag    = TAG_NONE;
		r.data   = b;
		nxt      = model_state;
		if (op == OP_RESTART) begin
			model_state       = ST_METHOD_START;
			model_major       = 8'd0;
			model_minor       = 8'd0;
			model_header_seen = 1'b0;
			r.data  = 8'd0;
			r.major = 8'd0;
			r.minor = 8'd0;
			return r;
		end
		case (model_state)
			ST_METHOD_START: begin
				if (token_char(b)) begin
					nxt = ST_METHOD;
					r.tag = TAG_METHOD;
				end else
					r.status = RES_BAD;
			end
			ST_METHOD: begin
				if (b == CH_SP)
					nxt = ST_URI;
				else if (token_char(b))
					r.tag = TAG_METHOD;
				else
					r.status = RES_BAD;
			end
			ST_URI: begin
				if (b == CH_SP)
					nxt = ST_VER_H;
				else if (control_char(b))
					r.status = RES_BAD;
				else
					r.tag = TAG_URI;
			end
			ST_VER_H: begin
				if (b == CH_H) nxt = ST_VER_T1; else r.status = RES_BAD;
			end
			ST_VER_T1: begin
				if (b == CH_T) nxt = ST_VER_T2; else r.status = RES_BAD;
			end
			ST_VER_T2: begin
				if (b == CH_T) nxt = ST_VER_P; else r.status = RES_BAD;
			end
			ST_VER_P: begin
				if (b == CH_P) nxt = ST_VER_SLASH; else r.status = RES_BAD;
			end
			ST_VER_SLASH: begin
				// The slash starts a fresh version number pair.
				if (b == CH_SLASH) begin
					model_major = 8'd0;
					model_minor = 8'd0;
					nxt = ST_MAJOR_START;
				end else
					r.status = RES_BAD;
			end
			ST_MAJOR_START: begin
				if (decimal_char(b)) begin
					model_major = push_decimal(model_major, b);
					nxt = ST_MAJOR;
				end else
					r.status = RES_BAD;
			end
			ST_MAJOR: begin
				if (b == CH_DOT)
					nxt = ST_MINOR_START;
				else if (decimal_char(b))
					model_major = push_decimal(model_major, b);
				else
					r.status = RES_BAD;
			end
			ST_MINOR_START: begin
				if (decimal_char(b)) begin
					model_minor = push_decimal(model_minor, b);
					nxt = ST_MINOR;
				end else
					r.status = RES_BAD;
			end
			ST_MINOR: begin
				if (b == CH_CR)
					nxt = ST_NL1;
				else if (decimal_char(b))
					model_minor = push_decimal(model_minor, b);
				else
					r.status = RES_BAD;
			end
			ST_NL1: begin
				if (b == CH_LF) nxt = ST_LINE_START; else r.status = RES_BAD;
			end
			ST_LINE_START: begin
				// Leading white space folds the line into the previous value,
				// but only once some header has been seen.
				if (b == CH_CR)
					nxt = ST_NL3;
				else if (model_header_seen && (b == CH_SP || b == CH_TAB))
					nxt = ST_LWS;
				else if (token_char(b)) begin
					model_header_seen = 1'b1;
					r.tag = TAG_NEW_NAME;
					nxt = ST_HNAME;
				end else
					r.status = RES_BAD;
			end
			ST_LWS: begin
				if (b == CH_CR)
					nxt = ST_NL2;
				else if (b == CH_SP || b == CH_TAB)
					nxt = ST_LWS;
				else if (control_char(b))
					r.status = RES_BAD;
				else begin
					nxt = ST_HVALUE;
					r.tag = TAG_VALUE;
				end
			end
			ST_HNAME: begin
				if (b == CH_COLON)
					nxt = ST_SPACE_BEFORE_VALUE;
				else if (token_char(b))
					r.tag = TAG_NAME;
				else
					r.status = RES_BAD;
			end
			ST_SPACE_BEFORE_VALUE: begin
				if (b == CH_SP) nxt = ST_HVALUE; else r.status = RES_BAD;
			end
			ST_HVALUE: begin
				if (b == CH_CR)
					nxt = ST_NL2;
				else if (control_char(b))
					r.status = RES_BAD;
				else
					r.tag = TAG_VALUE;
			end
			ST_NL2: begin
				if (b == CH_LF) nxt = ST_LINE_START; else r.status = RES_BAD;
			end
			ST_NL3: begin
				// The parser stays here after a complete request.
				r.status = (b == CH_LF) ? RES_DONE : RES_BAD;
			end
			default: r.status = RES_BAD;
		endcase
		model_state = nxt;
		r.major = model_major;
		r.minor = model_minor;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus building.
	// ------------------------------------------------------------------
	function automatic req_item_t consume(input logic [7:0] b);
		req_item_t it;
		it.op   = OP_CONSUME;
		it.data = b;
		return it;
	endfunction

	function automatic logic [7:0] pick_token();
		logic [7:0] v;
		do
			v = 8'($urandom_range(33, 126));
		while (!token_char(v));
		return v;
	endfunction

	// Any printable or high byte except DEL; spaces allowed when lo is 32.
	function automatic logic [7:0] pick_text(input int lo);
		logic [7:0] v;
		do
			v = 8'($urandom_range(lo, 255));
		while (v == CH_DEL);
		return v;
	endfunction

	function automatic logic [7:0] pick_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			pending_bytes.insert(pending_bytes.size(), consume(s[i]));
	endtask

	// Opening sequence: restart, a bad first byte, a request with the top
	// byte value in its URI and a version major that saturates, the blank
	// line, then a repeated line feed and a bad byte after completion.
	task automatic add_opening();
		req_item_t it;
		it.op   = OP_RESTART;
		it.data = 8'hFF;
		pending_bytes.insert(pending_bytes.size(), it);
		pending_bytes.insert(pending_bytes.size(), consume(8'h00));
		push_text("A /");
		pending_bytes.insert(pending_bytes.size(), consume(8'hFF));
		push_text(" HTTP/999.0");
		pending_bytes.insert(pending_bytes.size(), consume(CH_CR));
		pending_bytes.insert(pending_bytes.size(), consume(CH_LF));
		pending_bytes.insert(pending_bytes.size(), consume(CH_CR));
		pending_bytes.insert(pending_bytes.size(), consume(CH_LF));
		pending_bytes.insert(pending_bytes.size(), consume(CH_LF));
		push_text("X");
	endtask

	// A whole request with random content. One in four gets a byte or an
	// operation overwritten somewhere after its opening restart.
	task automatic add_request();
		req_item_t seq[$];
		req_item_t it;
		int        idx;
		it.op   = OP_RESTART;
		it.data = 8'($urandom_range(0, 255));
		seq.insert(seq.size(), it);
		repeat ($urandom_range(1, 6)) seq.insert(seq.size(), consume(pick_token()));
		seq.insert(seq.size(), consume(CH_SP));
		repeat ($urandom_range(1, 8)) seq.insert(seq.size(), consume(pick_text(33)));
		seq.insert(seq.size(), consume(CH_SP));
		seq.insert(seq.size(), consume(CH_H));
		seq.insert(seq.size(), consume(CH_T));
		seq.insert(seq.size(), consume(CH_T));
		seq.insert(seq.size(), consume(CH_P));
		seq.insert(seq.size(), consume(CH_SLASH));
		repeat ($urandom_range(1, 4)) seq.insert(seq.size(), consume(pick_digit()));
		seq.insert(seq.size(), consume(CH_DOT));
		repeat ($urandom_range(1, 4)) seq.insert(seq.size(), consume(pick_digit()));
		seq.insert(seq.size(), consume(CH_CR));
		seq.insert(seq.size(), consume(CH_LF));
		repeat ($urandom_range(0, 3)) begin
			repeat ($urandom_range(1, 6))
				seq.insert(seq.size(), consume(pick_token()));
			seq.insert(seq.size(), consume(CH_COLON));
			seq.insert(seq.size(), consume(CH_SP));
			repeat ($urandom_range(0, 6))
				seq.insert(seq.size(), consume(pick_text(32)));
			seq.insert(seq.size(), consume(CH_CR));
			seq.insert(seq.size(), consume(CH_LF));
			// Sometimes continue the value on a folded line.
			if ($urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(1, 2))
					seq.insert(seq.size(),
						consume($urandom_range(0, 1) ? CH_SP : CH_TAB));
				repeat ($urandom_range(0, 5))
					seq.insert(seq.size(), consume(pick_text(32)));
				seq.insert(seq.size(), consume(CH_CR));
				seq.insert(seq.size(), consume(CH_LF));
			end
		end
		seq.insert(seq.size(), consume(CH_CR));
		seq.insert(seq.size(), consume(CH_LF));
		if ($urandom_range(0, 2) == 0)
			seq.insert(seq.size(), consume(CH_LF));
		if ($urandom_range(0, 3) == 0) begin
			idx = $urandom_range(1, seq.size() - 1);
			seq[idx].data = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 5) == 0)
				seq[idx].op = OP_RESTART;
		end
		foreach (seq[i])
			pending_bytes.insert(pending_bytes.size(), seq[i]);
	endtask

	// Raw noise: random bytes with an occasional restart.
	task automatic add_noise();
		req_item_t it;
		repeat ($urandom_range(5, 20)) begin
			it.op   = ($urandom_range(0, 15) == 0) ? OP_RESTART : OP_CONSUME;
			it.data = 8'($urandom_range(0, 255));
			pending_bytes.insert(pending_bytes.size(), it);
		end
	endtask

	// ------------------------------------------------------------------
	// Driver. At each edge it first books the item the block just took,
	// then, if the channel is free, either idles or presents the next one.
	// A stalled item is held unchanged until the block takes it.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				results_due.insert(results_due.size(), parse_item(operation, byte_in));
				accepted_items++;
			end
			if (!req_valid || !req_stall) begin
				if (calm)
					send_gap = 0;
				else if (!quiet && send_gap == 0 && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 12);
				if (send_gap != 0 || pending_bytes.size() == 0) begin
					if (send_gap != 0)
						send_gap--;
					req_valid <= 1'b0;
				end else begin
					next_item = pending_bytes[0];
					pending_bytes.delete(0);
					req_valid <= 1'b1;
					operation <= next_item.op;
					byte_in   <= next_item.data;
				end
			end
			calm <= (pending_bytes.size() < CALM_TAIL);
		end
	end

	// ------------------------------------------------------------------
	// Result checking and receiver back-pressure.
	// ------------------------------------------------------------------
	task automatic flag_mismatch(input string what, input int got, input int exp_val);
		fail_count++;
		$display("MISMATCH result %0d %s: got %0d, expected %0d",
			result_index, what, got, exp_val);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (results_due.size() == 0)
					flag_mismatch("arrived with nothing outstanding", 0, 0);
				else begin
					want = results_due[0];
					results_due.delete(0);
					if (status !== want.status)
						flag_mismatch("status", status, want.status);
					if (field_tag !== want.tag)
						flag_mismatch("field_tag", field_tag, want.tag);
					if (byte_out !== want.data)
						flag_mismatch("byte_out", byte_out, want.data);
					if (version_major !== want.major)
						flag_mismatch("version_major", version_major, want.major);
					if (version_minor !== want.minor)
						flag_mismatch("version_minor", version_minor, want.minor);
				end
				result_index++;
			end
			if (calm)
				stall_left = 0;
			else if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 12);
			if (stall_left != 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else
				res_stall <= 1'b0;
		end
	end

	// Cycle limit, and the switch between idling and quiet stretches.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count % 128 == 0)
			quiet <= ($urandom_range(0, 3) == 0);
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("http_request_header_parser_unit verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence of the run: build all stimulus, release reset, wait until
	// every item has been taken and every result checked, then let the clock run
	// on to catch any stray result before the verdict.
	// ------------------------------------------------------------------
	initial begin
		add_opening();
		while (pending_bytes.size() < RANDOM_ITEMS) begin
			if ($urandom_range(0, 4) == 0)
				add_noise();
			else
				add_request();
		end
		total_items = pending_bytes.size();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (accepted_items != total_items || results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("http_request_header_parser_unit verification clean");
		else
			$display("http_request_header_parser_unit verification failed");
		$finish;
	end

endmodule
